/* design/rrts_pkg.sv */
package rrts_pkg;

  localparam int FUNC_W = 3;
  localparam int PIPE_IN_W = 3;
  localparam int VALUE_W = 64;
  localparam int STATUS_W = 3;
  localparam int RUN_W = 5;
  localparam int WR_W = 6;
  localparam int QUANT_W = 8;
  localparam logic [WR_W-1:0] WRITERS_MAX = 6'd63;
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd5;
  localparam logic REG_QUANTUM = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    F_CREATE    = 3'd0,
    F_TICK      = 3'd1,
    F_WRITE     = 3'd2,
    F_READ      = 3'd3,
    F_CAN_READ  = 3'd4,
    F_OPEN_WR   = 3'd5,
    F_CLOSE_WR  = 3'd6,
    F_EXIT      = 3'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    S_OK         = 3'd0,
    S_BLOCKED    = 3'd1,
    S_PREEMPTED  = 3'd2,
    S_END        = 3'd3,
    S_NO_THREAD  = 3'd4,
    S_TABLE_FULL = 3'd5,
    S_DROPPED    = 3'd6,
    S_DEADLOCK   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    T_READY    = 2'd0,
    T_RUNNING  = 2'd1,
    T_BLOCKED  = 2'd2,
    T_FINISHED = 2'd3
  } thread_st_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_EXEC,
    C_POST,
    C_SEARCH,
    C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic post;
    logic search;
  } cmd_t;

  typedef struct packed {
    logic need_dispatch;
    logic search_done;
  } stat_t;

endpackage

/* design/rrts_ctrl.sv */
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  input  rrts_pkg::stat_t stat,
  output rrts_pkg::cmd_t  cmd,
  output logic           in_ready,
  output logic           out_valid
);
  import rrts_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (in_valid) state_next = C_EXEC;
      end
      C_EXEC: state_next = C_POST;
      C_POST: begin
        state_next = stat.need_dispatch ? C_SEARCH : C_OUT;
      end
      C_SEARCH: begin
        if (stat.search_done) state_next = C_OUT;
      end
      C_OUT: begin
        if (out_ready) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      C_EXEC: cmd.exec = 1'b1;
      C_POST: cmd.post = 1'b1;
      C_SEARCH: cmd.search = 1'b1;
      C_OUT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* design/rrts_dp.sv */
module rrts_dp #(
  parameter int THREAD_SLOTS = 32,
  parameter int NUM_PIPES = 8,
  parameter int PIPE_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::cmd_t                cmd,
  output rrts_pkg::stat_t               stat,
  input  logic [rrts_pkg::FUNC_W-1:0]   in_func,
  input  logic [rrts_pkg::PIPE_IN_W-1:0] in_pipe,
  input  logic [rrts_pkg::VALUE_W-1:0]  in_value,
  input  logic                          cfg_we,
  input  logic [rrts_pkg::QUANT_W-1:0]  cfg_wdata,
  output logic [rrts_pkg::QUANT_W-1:0]  quantum,
  output logic [rrts_pkg::STATUS_W-1:0] out_status,
  output logic [rrts_pkg::VALUE_W-1:0]  out_data,
  output logic [rrts_pkg::RUN_W-1:0]    out_running,
  output logic                          out_active,
  output logic                          out_failed,
  output logic                          out_all_finished
);
  import rrts_pkg::*;

  localparam int TW = $clog2(THREAD_SLOTS);
  localparam int PW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int HW = $clog2(PIPE_DEPTH);
  localparam int FW = $clog2(PIPE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_PIPES * PIPE_DEPTH;
  localparam int MW = $clog2(MEM_DEPTH);

  // latched word
  func_t               func_r;
  logic [PW-1:0]       p_r;
  logic [VALUE_W-1:0]  val_r;

  thread_st_t          tstate [THREAD_SLOTS];
  logic [PW-1:0]       twait [THREAD_SLOTS];
  logic [TW:0]         total;
  logic [TW:0]         live;
  logic [TW-1:0]       sstart;
  logic [TW-1:0]       cur;
  logic                cv;
  logic [QUANT_W-1:0]  ql;
  logic                tp;
  logic                failed;
  logic [HW-1:0]       phead [NUM_PIPES];
  logic [FW-1:0]       pfill [NUM_PIPES];
  logic [WR_W-1:0]     pwr [NUM_PIPES];
  status_t             status_r;
  logic [VALUE_W-1:0]  data_r;
  logic                rd_pend;
  logic                wake_r;
  logic [TW-1:0]       sidx;
  logic [TW:0]         soff;

  logic [VALUE_W-1:0]  mem [MEM_DEPTH];
  logic [VALUE_W-1:0]  mem_q;

  logic [PW-1:0]       p_in;
  logic [PIPE_IN_W-1:0] p_v;
  logic [NUM_PIPES-1:0] ready_vec;
  logic [HW-1:0]       h;
  logic [FW-1:0]       f;
  logic [WR_W-1:0]     w;
  logic [HW+1:0]       slot_sum;
  logic [HW+1:0]       slot_wrap;
  logic [HW-1:0]       head_inc;
  logic [MW-1:0]       base;
  logic [MW-1:0]       waddr;
  logic [MW-1:0]       raddr;

  status_t             ex_status;
  logic [VALUE_W-1:0]  ex_data;
  logic ex_wr, ex_rd, fill_inc, fill_dec, wr_inc, wr_dec, make_thread, set_failed;
  logic tick_set, tick_clr, yield_cur, block_cur, finish_cur, ql_dec, ql_zero;
  logic wake_req, spend;

  logic                found;
  logic                last;
  logic [TW:0]         sidx_inc;
  logic [TW-1:0]       sstart_eff;

  // pipe index reduced modulo the pipe count
  always_comb begin
    p_v = in_pipe;
    for (int k = 0; k < 8; k++) begin
      if (int'(p_v) >= NUM_PIPES) p_v = PIPE_IN_W'(int'(p_v) - NUM_PIPES);
    end
    p_in = PW'(p_v);
  end

  always_comb begin
    for (int q = 0; q < NUM_PIPES; q++) begin
      ready_vec[q] = (pfill[q] != '0) || (pwr[q] == '0);
    end
  end

  assign h = phead[p_r];
  assign f = pfill[p_r];
  assign w = pwr[p_r];
  assign slot_sum = (HW+2)'(h) + (HW+2)'(f);
  assign slot_wrap = (slot_sum >= (HW+2)'(PIPE_DEPTH)) ? slot_sum - (HW+2)'(PIPE_DEPTH)
                                                        : slot_sum;
  assign head_inc = (h == HW'(PIPE_DEPTH - 1)) ? '0 : h + 1'b1;
  assign base = MW'(p_r) * MW'(PIPE_DEPTH);
  assign waddr = base + MW'(slot_wrap);
  assign raddr = base + MW'(h);

  always_comb begin
    ex_status = S_OK;
    ex_data = '0;
    ex_wr = 1'b0; ex_rd = 1'b0; fill_inc = 1'b0; fill_dec = 1'b0;
    wr_inc = 1'b0; wr_dec = 1'b0; make_thread = 1'b0; set_failed = 1'b0;
    tick_set = 1'b0; tick_clr = 1'b0; yield_cur = 1'b0; block_cur = 1'b0;
    finish_cur = 1'b0; ql_dec = 1'b0; ql_zero = 1'b0; wake_req = 1'b0; spend = 1'b0;
    case (func_r)
      F_CREATE: begin
        if (total >= (TW+1)'(THREAD_SLOTS)) begin
          set_failed = 1'b1;
          ex_status = S_TABLE_FULL;
          ex_data = '1;
        end else begin
          make_thread = 1'b1;
          ex_data = VALUE_W'(total);
        end
      end
      F_TICK: tick_set = 1'b1;
      default: begin
        if (!cv) begin
          ex_status = S_NO_THREAD;
        end else if ((func_r == F_WRITE || func_r == F_READ || func_r == F_CAN_READ) && tp) begin
          tick_clr = 1'b1;
          yield_cur = 1'b1;
          ex_status = S_PREEMPTED;
        end else begin
          case (func_r)
            F_WRITE: begin
              if (f >= FW'(PIPE_DEPTH)) begin
                ex_status = S_DROPPED;
              end else begin
                ex_wr = 1'b1;
                fill_inc = 1'b1;
              end
              wake_req = 1'b1;
              spend = 1'b1;
            end
            F_READ: begin
              if (f != '0) begin
                ex_rd = 1'b1;
                fill_dec = 1'b1;
                spend = 1'b1;
              end else if (w == '0) begin
                ex_status = S_END;
              end else begin
                block_cur = 1'b1;
                ex_status = S_BLOCKED;
              end
            end
            F_CAN_READ: begin
              if (f != '0) begin
                ex_data = VALUE_W'(1);
              end else if (w != '0) begin
                block_cur = 1'b1;
                ex_status = S_BLOCKED;
              end
            end
            F_OPEN_WR: begin
              wr_inc = (w < WRITERS_MAX);
              wake_req = 1'b1;
            end
            F_CLOSE_WR: begin
              wr_dec = (w != '0);
              wake_req = 1'b1;
              spend = 1'b1;
            end
            default: finish_cur = 1'b1;
          endcase
        end
      end
    endcase
    if (spend) begin
      if (tp) begin
        tick_clr = 1'b1;
        yield_cur = 1'b1;
      end else if (total > (TW+1)'(1)) begin
        if (ql <= QUANT_W'(1)) begin
          ql_zero = 1'b1;
          yield_cur = 1'b1;
        end else begin
          ql_dec = 1'b1;
        end
      end
    end
  end

  assign found = (tstate[sidx] == T_READY);
  assign last = (soff == total - 1'b1);
  assign sidx_inc = (TW+1)'(sidx) + 1'b1;
  assign sstart_eff = ((TW+1)'(sstart) >= total) ? '0 : sstart;

  assign stat.need_dispatch = !cv && !failed && (live != '0);
  assign stat.search_done = found || last;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= func_t'(in_func);
      p_r <= p_in;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ex_wr) mem[waddr] <= val_r;
    if (cmd.exec && ex_rd) mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        tstate[i] <= T_READY;
        twait[i] <= '0;
      end
      for (int q = 0; q < NUM_PIPES; q++) begin
        phead[q] <= '0;
        pfill[q] <= '0;
        pwr[q] <= '0;
      end
      total <= '0;
      live <= '0;
      sstart <= '0;
      cur <= '0;
      cv <= 1'b0;
      ql <= '0;
      tp <= 1'b0;
      failed <= 1'b0;
      quantum <= QUANTUM_RESET;
      status_r <= S_OK;
      data_r <= '0;
      rd_pend <= 1'b0;
      wake_r <= 1'b0;
      sidx <= '0;
      soff <= '0;
    end else begin
      if (cfg_we) quantum <= cfg_wdata;

      if (cmd.exec) begin
        status_r <= ex_status;
        data_r <= ex_data;
        rd_pend <= ex_rd;
        wake_r <= wake_req;
        if (make_thread) begin
          tstate[total[TW-1:0]] <= T_READY;
          twait[total[TW-1:0]] <= '0;
          total <= total + 1'b1;
          live <= live + 1'b1;
        end
        if (set_failed) failed <= 1'b1;
        if (tick_set) tp <= 1'b1;
        if (tick_clr) tp <= 1'b0;
        if (yield_cur) begin
          tstate[cur] <= T_READY;
          cv <= 1'b0;
        end
        if (block_cur) begin
          tstate[cur] <= T_BLOCKED;
          twait[cur] <= p_r;
          cv <= 1'b0;
        end
        if (finish_cur) begin
          tstate[cur] <= T_FINISHED;
          twait[cur] <= '0;
          cv <= 1'b0;
          live <= live - 1'b1;
        end
        if (ql_zero) ql <= '0;
        if (ql_dec) ql <= ql - 1'b1;
        if (fill_inc) pfill[p_r] <= f + 1'b1;
        if (fill_dec) begin
          pfill[p_r] <= f - 1'b1;
          phead[p_r] <= head_inc;
        end
        if (wr_inc) pwr[p_r] <= w + 1'b1;
        if (wr_dec) pwr[p_r] <= w - 1'b1;
      end

      if (cmd.post) begin
        if (rd_pend) data_r <= mem_q;
        // blocked threads whose pipe now has data or no writers become ready
        if (wake_r || stat.need_dispatch) begin
          for (int i = 0; i < THREAD_SLOTS; i++) begin
            if ((TW+1)'(i) < total && tstate[i] == T_BLOCKED && ready_vec[twait[i]]) begin
              tstate[i] <= T_READY;
              twait[i] <= '0;
            end
          end
        end
        sidx <= sstart_eff;
        soff <= '0;
      end

      if (cmd.search) begin
        if (found) begin
          sstart <= (sidx_inc >= (TW+1)'(THREAD_SLOTS)) ? '0 : sidx_inc[TW-1:0];
          cur <= sidx;
          cv <= 1'b1;
          ql <= quantum;
          tstate[sidx] <= T_RUNNING;
        end else if (last) begin
          failed <= 1'b1;
          status_r <= S_DEADLOCK;
        end else begin
          sidx <= (sidx_inc == total) ? '0 : sidx_inc[TW-1:0];
          soff <= soff + 1'b1;
        end
      end
    end
  end

  assign out_status = status_r;
  assign out_data = data_r;
  assign out_running = cv ? RUN_W'(cur) : '0;
  assign out_active = cv;
  assign out_failed = failed;
  assign out_all_finished = (live == '0);

endmodule

/* design/round_robin_thread_scheduler.sv */
// round robin thread scheduler with pipe fifos
// input channel (s_*): one event word per handshake, event code in s_tuser,
// pipe number and the value to push in s_tdata
// output channel (m_*): exactly one result word per event, status code in
// m_tuser, read data or created slot plus scheduler state in m_tdata
// apb port: register 0 (byte address 0) holds the quantum, operations a
// dispatched thread may complete before it yields
// an event is taken in the idle state, executed in the exec state, and the
// post state captures pipe read data and wakes blocked threads; the result
// is then shown, directly or after the round robin search when no thread is
// running, which checks one slot per cycle
// one event is in flight at a time; s_tready is high only while idle
// when the receiver stalls the result word holds on m_tdata and no new
// event is taken until it is accepted
// reset clears the thread table, pipe pointers, writer counts and flags and
// loads the default quantum; pipe storage needs no clearing
module round_robin_thread_scheduler #(
  parameter int THREAD_SLOTS = 32,
  parameter int NUM_PIPES = 8,
  parameter int PIPE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // pipe_index[2:0], write_value[66:3], zero pad
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // result_data[63:0], running_thread[68:64],
                                 // active flag[69], failed[70], all_finished[71]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrts_pkg::*;

  cmd_t                 cmd;
  stat_t                stat;
  logic                 cfg_we;
  logic [QUANT_W-1:0]   quantum;
  logic [STATUS_W-1:0]  out_status;
  logic [VALUE_W-1:0]   out_data;
  logic [RUN_W-1:0]     out_running;
  logic                 out_active;
  logic                 out_failed;
  logic                 out_all_finished;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_QUANTUM);
  assign prdata = (paddr[2] == REG_QUANTUM) ? {24'd0, quantum} : 32'd0;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  rrts_dp #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .NUM_PIPES    (NUM_PIPES),
    .PIPE_DEPTH   (PIPE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (s_tuser),
    .in_pipe            (s_tdata[2:0]),
    .in_value           (s_tdata[66:3]),
    .cfg_we             (cfg_we),
    .cfg_wdata          (pwdata[7:0]),
    .quantum            (quantum),
    .out_status         (out_status),
    .out_data           (out_data),
    .out_running        (out_running),
    .out_active         (out_active),
    .out_failed         (out_failed),
    .out_all_finished   (out_all_finished)
  );

  assign m_tuser = out_status;
  assign m_tdata = {out_all_finished, out_failed, out_active, out_running, out_data};

endmodule

/* sim/round_robin_thread_scheduler_test.sv */
module round_robin_thread_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int NTHR = 32;
  localparam int NPIPE = 8;
  localparam int DEPTH = 128;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] data;
    logic [4:0]  run_id;
    logic        running;
    logic        failed;
    logic        all_done;
  } sched_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  round_robin_thread_scheduler u_dut (.*);

  // scheduler shadow state
  logic [7:0]  quantum_cfg;
  thread_st_t  thr_st [NTHR];
  logic [2:0]  thr_wait [NTHR];
  int unsigned thr_count;
  int unsigned rr_start;
  int unsigned cur_thr;
  bit          cur_valid;
  int unsigned quantum_rem;
  bit          tick_flag;
  bit          fail_flag;
  logic [63:0] fifo_mem [NPIPE][DEPTH];
  int unsigned fifo_head [NPIPE];
  int unsigned fifo_fill [NPIPE];
  int unsigned fifo_wr [NPIPE];

  sched_result_t expected_q[$];
  int errors;
  int words_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic bit fifo_ready(input int unsigned p);
    return fifo_fill[p] > 0 || fifo_wr[p] == 0;
  endfunction

  function automatic void wake_blocked();
    for (int i = 0; i < thr_count; i++)
      if (thr_st[i] == T_BLOCKED && fifo_ready(thr_wait[i])) begin
        thr_st[i] = T_READY;
        thr_wait[i] = 0;
      end
  endfunction

  function automatic int unsigned live_threads();
    int unsigned n;
    n = 0;
    for (int i = 0; i < thr_count; i++)
      if (thr_st[i] != T_FINISHED) n++;
    return n;
  endfunction

  function automatic void yield_thread();
    thr_st[cur_thr] = T_READY;
    cur_valid = 0;
  endfunction

  function automatic void charge_quantum();
    if (tick_flag) begin
      tick_flag = 0;
      yield_thread();
    end else if (thr_count > 1) begin
      if (quantum_rem <= 1) begin
        quantum_rem = 0;
        yield_thread();
      end else begin
        quantum_rem--;
      end
    end
  endfunction

  function automatic void shadow_reset();
    quantum_cfg = QUANTUM_RESET;
    for (int i = 0; i < NTHR; i++) begin
      thr_st[i] = T_READY;
      thr_wait[i] = 0;
    end
    thr_count = 0; rr_start = 0; cur_thr = 0; cur_valid = 0;
    quantum_rem = 0; tick_flag = 0; fail_flag = 0;
    for (int p = 0; p < NPIPE; p++) begin
      fifo_head[p] = 0; fifo_fill[p] = 0; fifo_wr[p] = 0;
    end
  endfunction

  function automatic sched_result_t schedule_event(input func_t fn, input logic [2:0] p,
                                                   input logic [63:0] val);
    sched_result_t r;
    status_t st;
    logic [63:0] d;
    bit found;
    int unsigned idx, k;
    st = S_OK;
    d = '0;
    if (fn == F_CREATE) begin
      if (thr_count >= NTHR) begin
        fail_flag = 1;
        st = S_TABLE_FULL;
        d = '1;
      end else begin
        thr_st[thr_count] = T_READY;
        thr_wait[thr_count] = 0;
        d = thr_count;
        thr_count++;
      end
    end else if (fn == F_TICK) begin
      tick_flag = 1;
    end else if (!cur_valid) begin
      st = S_NO_THREAD;
    end else if ((fn == F_WRITE || fn == F_READ || fn == F_CAN_READ) && tick_flag) begin
      tick_flag = 0;
      yield_thread();
      st = S_PREEMPTED;
    end else begin
      case (fn)
        F_WRITE: begin
          if (fifo_fill[p] >= DEPTH) begin
            st = S_DROPPED;
          end else begin
            fifo_mem[p][(fifo_head[p] + fifo_fill[p]) % DEPTH] = val;
            fifo_fill[p]++;
          end
          wake_blocked();
          charge_quantum();
        end
        F_READ: begin
          if (fifo_fill[p] > 0) begin
            d = fifo_mem[p][fifo_head[p]];
            fifo_head[p] = (fifo_head[p] + 1) % DEPTH;
            fifo_fill[p]--;
            charge_quantum();
          end else if (fifo_wr[p] == 0) begin
            st = S_END;
          end else begin
            thr_st[cur_thr] = T_BLOCKED;
            thr_wait[cur_thr] = p;
            cur_valid = 0;
            st = S_BLOCKED;
          end
        end
        F_CAN_READ: begin
          if (fifo_fill[p] > 0) begin
            d = 1;
          end else if (fifo_wr[p] != 0) begin
            thr_st[cur_thr] = T_BLOCKED;
            thr_wait[cur_thr] = p;
            cur_valid = 0;
            st = S_BLOCKED;
          end
        end
        F_OPEN_WR: begin
          if (fifo_wr[p] < WRITERS_MAX) fifo_wr[p]++;
          wake_blocked();
        end
        F_CLOSE_WR: begin
          if (fifo_wr[p] > 0) fifo_wr[p]--;
          wake_blocked();
          charge_quantum();
        end
        default: begin
          thr_st[cur_thr] = T_FINISHED;
          thr_wait[cur_thr] = 0;
          cur_valid = 0;
        end
      endcase
    end
    if (!cur_valid && !fail_flag && live_threads() > 0) begin
      found = 0;
      idx = 0;
      wake_blocked();
      for (int off = 0; off < thr_count; off++) begin
        k = (rr_start + off) % thr_count;
        if (!found && thr_st[k] == T_READY) begin
          idx = k;
          found = 1;
        end
      end
      if (found) begin
        rr_start = (idx + 1 >= NTHR) ? 0 : idx + 1;
        cur_thr = idx;
        cur_valid = 1;
        quantum_rem = quantum_cfg;
        thr_st[idx] = T_RUNNING;
      end else begin
        fail_flag = 1;
        st = S_DEADLOCK;
      end
    end
    r.status = st;
    r.data = d;
    r.run_id = cur_valid ? cur_thr[4:0] : 5'd0;
    r.running = cur_valid;
    r.failed = fail_flag;
    r.all_done = live_threads() == 0;
    return r;
  endfunction

  // result checker with random receiver stalls
  initial begin
    sched_result_t exp_r;
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      words_seen++;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        exp_r = expected_q.pop_front();
        if (m_tuser !== exp_r.status)
          report($sformatf("status got %0d want %0d", m_tuser, exp_r.status));
        if (m_tdata[63:0] !== exp_r.data)
          report($sformatf("data got %h want %h", m_tdata[63:0], exp_r.data));
        if (m_tdata[68:64] !== exp_r.run_id)
          report($sformatf("running thread got %0d want %0d", m_tdata[68:64], exp_r.run_id));
        if (m_tdata[69] !== exp_r.running) report("active flag");
        if (m_tdata[70] !== exp_r.failed) report("failed flag");
        if (m_tdata[71] !== exp_r.all_done) report("all_finished flag");
      end
    end
  end

  task automatic send_event(input func_t fn, input logic [2:0] p, input logic [63:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {5'd0, val, p};
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(schedule_event(fn, p, val));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (NTHR + 8) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [7:0] q);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'd0; pwdata <= {24'd0, q};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    quantum_cfg = q;
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 5))
      0: w = 64'h8000_0000_0000_0000;
      1: w = 64'h7fff_ffff_ffff_ffff;
      2: w = '1;
      3: w = '0;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic test_directed();
    // nothing running yet
    send_event(F_WRITE, 3'd0, 64'd1);
    send_event(F_EXIT, 3'd7, 64'd0);
    send_event(F_CREATE, 3'd0, 64'd0);
    send_event(F_CREATE, 3'd0, 64'd0);
    send_event(F_OPEN_WR, 3'd7, 64'd0);
    send_event(F_WRITE, 3'd7, 64'h8000_0000_0000_0000);
    send_event(F_WRITE, 3'd7, 64'h7fff_ffff_ffff_ffff);
    send_event(F_CAN_READ, 3'd7, 64'd0);
    send_event(F_READ, 3'd7, 64'd0);
    send_event(F_TICK, 3'd0, 64'd0);
    send_event(F_READ, 3'd7, 64'd0);
    send_event(F_READ, 3'd7, '1);
    send_event(F_READ, 3'd7, 64'd0);
    send_event(F_READ, 3'd7, 64'd0);
    send_event(F_CLOSE_WR, 3'd7, 64'd0);
    send_event(F_CLOSE_WR, 3'd7, 64'd0);
    send_event(F_READ, 3'd5, 64'd0);
    send_event(F_CAN_READ, 3'd5, 64'd0);
    send_event(F_EXIT, 3'd0, 64'd0);
    send_event(F_EXIT, 3'd0, 64'd0);
    send_event(F_TICK, 3'd0, 64'd0);
    wait_idle();
  endtask

  // fill a pipe past its depth and saturate the writer count
  task automatic test_limits();
    send_event(F_CREATE, 3'd0, 64'd0);
    for (int i = 0; i < 66; i++) send_event(F_OPEN_WR, 3'd2, 64'd0);
    for (int i = 0; i < DEPTH + 3; i++) send_event(F_WRITE, 3'd2, rand_word());
    for (int i = 0; i < DEPTH; i++) send_event(F_READ, 3'd2, 64'd0);
    send_event(F_EXIT, 3'd0, 64'd0);
    wait_idle();
  endtask

  task automatic test_random(input int n_items);
    int unsigned r;
    func_t fn;
    logic [2:0] p;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 3) == 0 ? 3'($urandom) : 3'($urandom_range(0, 2));
      if (r < 4 && thr_count < NTHR) fn = F_CREATE;
      else if (r < 8) fn = F_TICK;
      else if (r < 35) fn = F_WRITE;
      else if (r < 60) fn = F_READ;
      else if (r < 70) fn = F_CAN_READ;
      else if (r < 82) fn = F_OPEN_WR;
      else if (r < 94) fn = F_CLOSE_WR;
      else if (r < 98) fn = F_EXIT;
      else fn = func_t'($urandom_range(0, 7));
      send_event(fn, p, rand_word());
    end
    wait_idle();
  endtask

  task automatic test_table_overflow();
    for (int i = 0; i < 4; i++) send_event(F_CREATE, 3'd0, 64'd0);
    wait_idle();
  endtask

  initial begin
    logic [7:0] q_set [5] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2};
    errors = 0;
    words_seen = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    shadow_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    foreach (q_set[i]) begin
      write_quantum(q_set[i]);
      test_random(220);
    end
    test_table_overflow();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
